// ===== rtl/mandelbrot_escape_time_defines.svh =====
// Assertion macros shared by the escape-time RTL modules.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define MBE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// When cond holds at one edge, expr must hold at the next edge.
`define MBE_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/mbe_pkg.sv =====
// Shared types, constants and fixed-point helpers for the escape-time block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package mbe_pkg;

    localparam int MAX_ITER    = 256;
    localparam int FRAC_BITS   = 28;
    localparam int INDEX_BITS  = 12;

    localparam int WORD_W      = 32;
    localparam int STEP_W      = WORD_W - 1;
    localparam int WIDE_W      = 2 * WORD_W;
    localparam int PROD_W      = INDEX_BITS + STEP_W;
    localparam int ITER_W      = 9;

    localparam int S_TDATA_W   = ((2 * INDEX_BITS + 7) / 8) * 8;
    localparam int M_FIELD_W   = 2 * INDEX_BITS + ITER_W;
    localparam int M_TDATA_W   = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELD_W;

    localparam int CFG_INDEX_W = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_X_ORIGIN = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_Y_ORIGIN = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_X_STEP   = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_Y_STEP   = CFG_INDEX_W'(3);

    localparam logic signed [WORD_W-1:0] X_ORIGIN_RESET = -32'sd536870912;
    localparam logic signed [WORD_W-1:0] Y_ORIGIN_RESET = -32'sd402653184;
    localparam logic [STEP_W-1:0]        X_STEP_RESET   = 31'd786432;
    localparam logic [STEP_W-1:0]        Y_STEP_RESET   = 31'd786432;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

    // Escape threshold |z|^2 >= 4 in the fixed-point scale.
    localparam logic [WIDE_W-1:0] SQ_LIMIT = WIDE_W'(4) << FRAC_BITS;

    // One pixel with its point c, as handed from the front end to the core.
    typedef struct packed {
        logic signed [WORD_W-1:0] c_re;
        logic signed [WORD_W-1:0] c_im;
        logic [INDEX_BITS-1:0]    column;
        logic [INDEX_BITS-1:0]    row;
    } point_t;

    // Clamp a wide signed value to the signed word range.
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > WIDE_W'(WORD_MAX)) begin
            r = WORD_MAX;
        end else if (v < WIDE_W'(WORD_MIN)) begin
            r = WORD_MIN;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    // Scale a square down by the fraction bits (floor) and clamp to 0..2^31-1.
    function automatic logic [WORD_W-2:0] sat_square(input logic signed [WIDE_W-1:0] p);
        logic signed [WIDE_W-1:0] s;
        logic [WORD_W-2:0]        r;
        s = p >>> FRAC_BITS;
        if (s > WIDE_W'(WORD_MAX)) begin
            r = '1;
        end else begin
            r = s[WORD_W-2:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mbe_front.sv =====
// Front end: configuration registers, pixel intake and forming of point c.
// Depends on mbe_pkg; feeds the pixel queue.
`default_nettype none

module mbe_front
    import mbe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]      cfg_data,
    input  wire logic                   pix_valid,
    output logic                        pix_ready,
    input  wire logic [INDEX_BITS-1:0]  pix_column,
    input  wire logic [INDEX_BITS-1:0]  pix_row,
    output logic                        push_valid,
    input  wire logic                   push_ready,
    output point_t                      push_data
);

    logic signed [WORD_W-1:0] x_origin_reg;
    logic signed [WORD_W-1:0] y_origin_reg;
    logic [STEP_W-1:0]        x_step_reg;
    logic [STEP_W-1:0]        y_step_reg;

    logic                     s1_valid_reg;
    logic [PROD_W-1:0]        prod_x_reg;
    logic [PROD_W-1:0]        prod_y_reg;
    logic [INDEX_BITS-1:0]    col_reg;
    logic [INDEX_BITS-1:0]    row_reg;

    logic signed [WIDE_W-1:0] sum_x;
    logic signed [WIDE_W-1:0] sum_y;
    logic                     take;

    assign cfg_ready  = 1'b1;
    assign pix_ready  = !s1_valid_reg || push_ready;
    assign take       = pix_valid && pix_ready;
    assign push_valid = s1_valid_reg;

    // The index product is non-negative; add the origin exactly, then clamp.
    assign sum_x = WIDE_W'(x_origin_reg) + WIDE_W'(signed'({1'b0, prod_x_reg}));
    assign sum_y = WIDE_W'(y_origin_reg) + WIDE_W'(signed'({1'b0, prod_y_reg}));

    always_comb
    begin
        push_data.c_re   = sat_word(sum_x);
        push_data.c_im   = sat_word(sum_y);
        push_data.column = col_reg;
        push_data.row    = row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= X_ORIGIN_RESET;
            y_origin_reg <= Y_ORIGIN_RESET;
            x_step_reg   <= X_STEP_RESET;
            y_step_reg   <= Y_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_ORIGIN: x_origin_reg <= cfg_data;
                REG_Y_ORIGIN: y_origin_reg <= cfg_data;
                REG_X_STEP:   x_step_reg   <= cfg_data[STEP_W-1:0];
                REG_Y_STEP:   y_step_reg   <= cfg_data[STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_x_reg <= pix_column * x_step_reg;
            prod_y_reg <= pix_row * y_step_reg;
            col_reg    <= pix_column;
            row_reg    <= pix_row;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mbe_queue.sv =====
// Short first-in first-out queue of pixels between front end and core.
// Depends on mbe_pkg and the assertion macros header.
`default_nettype none
`include "mandelbrot_escape_time_defines.svh"

module mbe_queue
    import mbe_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire point_t push_data,
    output logic        pop_valid,
    input  wire logic   pop_ready,
    output point_t      pop_data
);

    point_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `MBE_ASSERT(a_queue_bound, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue fill exceeds depth")
    `MBE_ASSERT_NEXT(a_queue_grow, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue fill did not grow on push")

endmodule

`default_nettype wire

// ===== rtl/mbe_core.sv =====
// Iteration core: runs z = z*z + c for one pixel at a time and holds the result word.
// Depends on mbe_pkg and the assertion macros header.
`default_nettype none
`include "mandelbrot_escape_time_defines.svh"

module mbe_core
    import mbe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire point_t            pop_data,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic [INDEX_BITS-1:0]  res_column,
    output logic [INDEX_BITS-1:0]  res_row,
    output logic [ITER_W-1:0]      res_iterations,
    output logic                   res_escaped
);

    typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_t;

    state_t                   state_reg,   state_next;
    logic [ITER_W-1:0]        cnt_reg,     cnt_next;
    logic signed [WORD_W-1:0] c_re_reg,    c_re_next;
    logic signed [WORD_W-1:0] c_im_reg,    c_im_next;
    logic [INDEX_BITS-1:0]    col_reg,     col_next;
    logic [INDEX_BITS-1:0]    row_reg,     row_next;
    logic [WORD_W-2:0]        re2_reg,     re2_next;
    logic [WORD_W-2:0]        im2_reg,     im2_next;
    logic signed [WIDE_W-1:0] pim_reg,     pim_next;
    logic                     m_valid_reg, m_valid_next;
    logic [INDEX_BITS-1:0]    out_col_reg, out_col_next;
    logic [INDEX_BITS-1:0]    out_row_reg, out_row_next;
    logic [ITER_W-1:0]        out_iter_reg, out_iter_next;
    logic                     out_esc_reg, out_esc_next;

    logic signed [WIDE_W-1:0] re_acc;
    logic signed [WIDE_W-1:0] im_acc;
    logic signed [WORD_W-1:0] re_new;
    logic signed [WORD_W-1:0] im_new;
    logic signed [WIDE_W-1:0] re_sq;
    logic signed [WIDE_W-1:0] im_sq;
    logic signed [WIDE_W-1:0] reim_prod;
    logic [WORD_W-1:0]        mag;
    logic                     escape;
    logic                     done;
    logic                     out_free;

    // The product re*im of the previous round is kept whole, so each path of a
    // round is the adds, a clamp, one multiplier and a second clamp of the square.
    assign re_acc    = WIDE_W'(signed'({1'b0, re2_reg})) - WIDE_W'(signed'({1'b0, im2_reg}))
                     + WIDE_W'(c_re_reg);
    assign im_acc    = (pim_reg >>> (FRAC_BITS - 1)) + WIDE_W'(c_im_reg);
    assign re_new    = sat_word(re_acc);
    assign im_new    = sat_word(im_acc);
    assign re_sq     = re_new * re_new;
    assign im_sq     = im_new * im_new;
    assign reim_prod = re_new * im_new;

    assign mag      = {1'b0, re2_reg} + {1'b0, im2_reg};
    assign escape   = (WIDE_W'(mag) >= SQ_LIMIT);
    assign done     = escape || (cnt_reg == ITER_W'(MAX_ITER));
    assign out_free = !m_valid_reg || res_ready;

    assign pop_ready      = (state_reg == ST_IDLE);
    assign res_valid      = m_valid_reg;
    assign res_column     = out_col_reg;
    assign res_row        = out_row_reg;
    assign res_iterations = out_iter_reg;
    assign res_escaped    = out_esc_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        c_re_next     = c_re_reg;
        c_im_next     = c_im_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        re2_next      = re2_reg;
        im2_next      = im2_reg;
        pim_next      = pim_reg;
        m_valid_next  = m_valid_reg && !res_ready;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_iter_next = out_iter_reg;
        out_esc_next  = out_esc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    c_re_next  = pop_data.c_re;
                    c_im_next  = pop_data.c_im;
                    col_next   = pop_data.column;
                    row_next   = pop_data.row;
                    re2_next   = '0;
                    im2_next   = '0;
                    pim_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (done)
                begin
                    if (out_free)
                    begin
                        m_valid_next  = 1'b1;
                        out_col_next  = col_reg;
                        out_row_next  = row_reg;
                        out_iter_next = cnt_reg;
                        out_esc_next  = escape;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    re2_next = sat_square(re_sq);
                    im2_next = sat_square(im_sq);
                    pim_next = reim_prod;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            c_re_reg     <= '0;
            c_im_reg     <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            re2_reg      <= '0;
            im2_reg      <= '0;
            pim_reg      <= '0;
            m_valid_reg  <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_iter_reg <= '0;
            out_esc_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            c_re_reg     <= c_re_next;
            c_im_reg     <= c_im_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            re2_reg      <= re2_next;
            im2_reg      <= im2_next;
            pim_reg      <= pim_next;
            m_valid_reg  <= m_valid_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_iter_reg <= out_iter_next;
            out_esc_reg  <= out_esc_next;
        end
    end

    `MBE_ASSERT(a_cnt_bound, cnt_reg <= ITER_W'(MAX_ITER), "round count passed the limit")
    `MBE_ASSERT(a_limit_flag, (m_valid_reg && !out_esc_reg) |-> (out_iter_reg == ITER_W'(MAX_ITER)), "bounded result without full round count")
    `MBE_ASSERT_NEXT(a_pop_run, pop_valid && pop_ready, state_reg == ST_RUN, "pixel taken but core not running")

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time block: ports, packing and module wiring.
// Depends on mbe_pkg, mbe_front, mbe_queue and mbe_core.
//
// Usage:
//   The slave stream takes one word per pixel: column and row indices. The
//   master stream returns one word per pixel with the same indices, the
//   number of rounds of z = z*z + c done from z = 0, and in tuser a flag that
//   is set when |z|^2 reached 4 and clear when the round limit was hit.
//   The configuration channel writes the origin and per-index step of the
//   view (index 0 x_origin, 1 y_origin in Q4.28, 2 x_step, 3 y_step in UQ3.28);
//   writes to other indices are dropped. cfg_ready is always high, and
//   writes are meant to happen only while no pixel is in flight.
//   The core holds one pixel at a time: it loads the point, runs one round of
//   the complex recurrence per cycle through its three multipliers (1 to 256
//   rounds done) and then writes the finished word into the output register.
//   The front end forms c for the next pixels while the core iterates and
//   parks them in a two-word queue; input stalls once it and its register are full.
//   If the receiver stalls, the finished word waits in the output register
//   and the core holds its last pixel until the register frees up.
//   Reset (rst_n low, asynchronous) empties the queue, drops any pixel in
//   progress and any pending result, and restores the default view registers.
`default_nettype none

module mandelbrot_escape_time
    import mbe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]      cfg_data,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0: column[11:0], row[23:12].
    input  wire logic [S_TDATA_W-1:0]   s_axis_tdata,

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // Fields from bit 0: column_out[11:0], row_out[23:12], iterations[32:24], zero pad.
    output logic [M_TDATA_W-1:0]        m_axis_tdata,
    // Fields from bit 0: escaped[0].
    output logic                        m_axis_tuser
);

    logic                  q_push_valid;
    logic                  q_push_ready;
    point_t                q_push_data;
    logic                  q_pop_valid;
    logic                  q_pop_ready;
    point_t                q_pop_data;

    logic [INDEX_BITS-1:0] res_column;
    logic [INDEX_BITS-1:0] res_row;
    logic [ITER_W-1:0]     res_iterations;

    // Front end: view registers and the index-times-step products.
    mbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_valid  (s_axis_tvalid),
        .pix_ready  (s_axis_tready),
        .pix_column (s_axis_tdata[INDEX_BITS-1:0]),
        .pix_row    (s_axis_tdata[2*INDEX_BITS-1:INDEX_BITS]),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    // Queue of ready points so the front end keeps taking words during a long pixel.
    mbe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // Iteration core with the output register.
    mbe_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (q_pop_valid),
        .pop_ready      (q_pop_ready),
        .pop_data       (q_pop_data),
        .res_valid      (m_axis_tvalid),
        .res_ready      (m_axis_tready),
        .res_column     (res_column),
        .res_row        (res_row),
        .res_iterations (res_iterations),
        .res_escaped    (m_axis_tuser)
    );

    assign m_axis_tdata = {{M_PAD_W{1'b0}}, res_iterations, res_row, res_column};

endmodule

`default_nettype wire

// ===== bench/mandelbrot_escape_time_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mandelbrot_escape_time: streams pixel words in, predicts each
// escape count with a fixed-point model of its own and checks the result words in order.
// Depends on mbe_pkg and the mandelbrot_escape_time RTL.

module mandelbrot_escape_time_test;
    import mbe_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 4;
    // Longest time one pixel may spend in the core, plus the output register.
    localparam int LATENCY_MAX    = MAX_ITER + 3;
    // Length of the one long output hold-off that fills the block up.
    localparam int HOLD_CYCLES    = 1500;
    // Cycles without any accepted word before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4 * HOLD_CYCLES + 10 * LATENCY_MAX;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_VIEWS    = 4;
    localparam int VIEW_ITEMS     = 103;
    localparam logic [INDEX_BITS-1:0] INDEX_TOP = '1;

    localparam longint WORD_TOP     = 64'sh7FFF_FFFF;
    localparam longint WORD_BOTTOM  = -64'sh8000_0000;
    localparam longint ESCAPE_LIMIT = 64'sd4 <<< FRAC_BITS;

    // Q4.28 constants used by the directed views.
    localparam logic [WORD_W-1:0] Q_ZERO    = '0;
    localparam logic [WORD_W-1:0] Q_TWO     = WORD_W'(2) << FRAC_BITS;
    localparam logic [WORD_W-1:0] STEP_FULL = 32'h7FFF_FFFF;
    // Just right of the cusp at 0.25, where the escape count climbs past the limit.
    localparam logic [WORD_W-1:0] CUSP_RE   = 32'd67135708;
    localparam logic [WORD_W-1:0] CUSP_STEP = 32'd268;

    // Window over the interesting part of the plane for random views.
    localparam int WINDOW_RE_LOW = -671088640;
    localparam int WINDOW_IM_LOW = -402653184;
    localparam int WINDOW_SPAN   = 805306368;
    localparam int WINDOW_STEP   = 196608;

    // Register indexes that the block has no register behind.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] REG_LAST  = '1;

    typedef struct packed {
        logic [INDEX_BITS-1:0] column;
        logic [INDEX_BITS-1:0] row;
        logic [ITER_W-1:0]     iterations;
        logic                  escaped;
    } pixel_result_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [WORD_W-1:0]      cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;

    // The view registers as the testbench believes them to be.
    logic signed [WORD_W-1:0] view_x_origin = X_ORIGIN_RESET;
    logic signed [WORD_W-1:0] view_y_origin = Y_ORIGIN_RESET;
    logic [STEP_W-1:0]        view_x_step   = X_STEP_RESET;
    logic [STEP_W-1:0]        view_y_step   = Y_STEP_RESET;

    // Escape results of accepted pixels, oldest first.
    pixel_result_t pending_pixels[$];
    pixel_result_t got_pixel;
    pixel_result_t want_pixel;

    int pixels_sent        = 0;
    int results_seen       = 0;
    int escaped_seen       = 0;
    int mismatches         = 0;
    int views_set          = 0;
    int reg_writes         = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int hold_seen          = 0;
    int hold_left          = 0;
    int quiet_cycles       = 0;

    mandelbrot_escape_time dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WORD_TOP)
            return WORD_TOP;
        if (v < WORD_BOTTOM)
            return WORD_BOTTOM;
        return v;
    endfunction

    // Escape-time prediction for one pixel under the current view. All values are
    // held at 64 bits, so every product is exact before it is scaled down; the
    // arithmetic right shift of a signed value rounds toward minus infinity.
    function automatic pixel_result_t escape_time_of(input logic [INDEX_BITS-1:0] column,
                                                     input logic [INDEX_BITS-1:0] row);
        pixel_result_t result;
        longint c_re;
        longint c_im;
        longint re;
        longint im;
        longint re_sq;
        longint im_sq;
        int rounds;
        c_re   = clamp_word(longint'(view_x_origin) + longint'(column) * longint'(view_x_step));
        c_im   = clamp_word(longint'(view_y_origin) + longint'(row) * longint'(view_y_step));
        re     = 0;
        im     = 0;
        re_sq  = 0;
        im_sq  = 0;
        rounds = 0;
        while (rounds < MAX_ITER && re_sq + im_sq < ESCAPE_LIMIT)
        begin
            // The imaginary part uses the old real part, so it goes first.
            im    = clamp_word(((re * im) >>> (FRAC_BITS - 1)) + c_im);
            re    = clamp_word(re_sq - im_sq + c_re);
            re_sq = (re * re) >>> FRAC_BITS;
            if (re_sq > WORD_TOP)
                re_sq = WORD_TOP;
            im_sq = (im * im) >>> FRAC_BITS;
            if (im_sq > WORD_TOP)
                im_sq = WORD_TOP;
            rounds++;
        end
        result.column     = column;
        result.row        = row;
        result.iterations = ITER_W'(rounds);
        result.escaped    = (re_sq + im_sq >= ESCAPE_LIMIT);
        return result;
    endfunction

    // Writes one register and leaves cfg_valid high; the caller lowers it once the
    // last write of a group has gone through.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
                             input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_writes++;
        case (reg_index)
            REG_X_ORIGIN: view_x_origin = value;
            REG_Y_ORIGIN: view_y_origin = value;
            REG_X_STEP:   view_x_step   = value[STEP_W-1:0];
            REG_Y_STEP:   view_y_step   = value[STEP_W-1:0];
            default:      ;
        endcase
    endtask

    // Loads a whole view. Only called after settle, with no pixel in flight.
    task automatic set_view(input logic [WORD_W-1:0] x_origin, input logic [WORD_W-1:0] y_origin,
                            input logic [WORD_W-1:0] x_step, input logic [WORD_W-1:0] y_step);
        write_reg(REG_X_ORIGIN, x_origin);
        write_reg(REG_Y_ORIGIN, y_origin);
        write_reg(REG_X_STEP, x_step);
        write_reg(REG_Y_STEP, y_step);
        cfg_valid <= 1'b0;
        views_set++;
    endtask

    // Stops offering pixels and waits until every pending result word has come back.
    // Each pixel yields exactly one result, so the block is idle at that point.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Offers one pixel word, with random idle cycles in front of it. On return the
    // word has been accepted and tvalid is still high, so a following word can go
    // out back to back without the valid dropping in between.
    task automatic send_pixel(input logic [INDEX_BITS-1:0] column,
                              input logic [INDEX_BITS-1:0] row);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row, column};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_pixels.push_back(escape_time_of(column, row));
        pixels_sent++;
    endtask

    // Mostly windows over the set with small steps, so that many pixels iterate for a
    // while; now and then fully random registers or the step extremes.
    task automatic random_view();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            set_view($urandom, $urandom, $urandom, $urandom);
        else if (pick == 1)
            set_view($urandom, $urandom, $urandom_range(1) ? STEP_FULL : Q_ZERO,
                     $urandom_range(1) ? STEP_FULL : Q_ZERO);
        else
            set_view(WORD_W'(WINDOW_RE_LOW + int'($urandom_range(WINDOW_SPAN))),
                     WORD_W'(WINDOW_IM_LOW + int'($urandom_range(WINDOW_SPAN))),
                     WORD_W'($urandom_range(WINDOW_STEP)), WORD_W'($urandom_range(WINDOW_STEP)));
    endtask

    // The view left by reset, probed at its corners and at alternating bit patterns.
    task automatic test_reset_view();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_pixel('0, '0);
        send_pixel(INDEX_TOP, INDEX_TOP);
        send_pixel(INDEX_TOP, '0);
        send_pixel('0, INDEX_TOP);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
    endtask

    // c = 0 never escapes and runs the full round limit. Writes to indexes with no
    // register behind them must leave the view alone. c = 2 lands exactly on the
    // threshold after one round, which counts as escaped.
    task automatic test_special_points();
        settle();
        set_view(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_pixel('0, '0);
        send_pixel(INDEX_TOP, INDEX_TOP);
        settle();
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        write_reg(REG_LAST, 32'h4000_0000);
        cfg_valid <= 1'b0;
        send_pixel(12'h5A5, 12'hA5A);
        settle();
        set_view(Q_TWO, Q_ZERO, Q_ZERO, Q_ZERO);
        send_pixel(INDEX_BITS'(7), INDEX_BITS'(9));
    endtask

    // Register extremes: the coordinates overflow 32 bits and must saturate, and the
    // squares of the saturated parts must clamp before the compare.
    task automatic test_saturation();
        settle();
        set_view(WORD_MAX, WORD_MIN, STEP_FULL, STEP_FULL);
        send_pixel('0, '0);
        send_pixel(INDEX_BITS'(1), INDEX_BITS'(1));
        send_pixel(INDEX_TOP, '0);
        send_pixel(INDEX_TOP, INDEX_TOP);
        settle();
        set_view(WORD_MIN, WORD_MAX, Q_ZERO, Q_ZERO);
        send_pixel('0, '0);
        send_pixel(INDEX_TOP, INDEX_TOP);
    endtask

    // Along the real axis just past the cusp the escape count falls by about one per
    // column, so some column escapes in the very last round. Find it with the model.
    task automatic test_last_round_escape();
        pixel_result_t probe;
        int hit;
        settle();
        set_view(CUSP_RE, Q_ZERO, CUSP_STEP, Q_ZERO);
        hit = 1;
        for (int col = 1; col < INDEX_TOP; col++)
        begin
            probe = escape_time_of(INDEX_BITS'(col), '0);
            if (probe.escaped && probe.iterations == ITER_W'(MAX_ITER))
            begin
                hit = col;
                break;
            end
        end
        send_pixel(INDEX_BITS'(hit - 1), '0);
        send_pixel(INDEX_BITS'(hit), '0);
        send_pixel(INDEX_BITS'(hit + 1), '0);
    endtask

    // The receiver holds off for a long stretch while pixels keep coming, so the output
    // register, the core and the queue all fill up and the input must stall.
    task automatic test_backpressure();
        settle();
        set_view(X_ORIGIN_RESET, Y_ORIGIN_RESET, WORD_W'(X_STEP_RESET), WORD_W'(Y_STEP_RESET));
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_requests <= hold_requests + 1;
        repeat (12)
            send_pixel(INDEX_BITS'($urandom_range(INDEX_TOP)), INDEX_BITS'($urandom_range(INDEX_TOP)));
    endtask

    // Random pixels under a few random views, with the given idle and stall rates.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (PHASE_VIEWS)
        begin
            settle();
            random_view();
            repeat (VIEW_ITEMS)
                send_pixel(INDEX_BITS'($urandom_range(INDEX_TOP)),
                           INDEX_BITS'($urandom_range(INDEX_TOP)));
        end
    endtask

    // Output side: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Every accepted result word is compared with the oldest pending prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_pixel.column     = m_axis_tdata[INDEX_BITS-1:0];
            got_pixel.row        = m_axis_tdata[2*INDEX_BITS-1:INDEX_BITS];
            got_pixel.iterations = m_axis_tdata[2*INDEX_BITS+ITER_W-1:2*INDEX_BITS];
            got_pixel.escaped    = m_axis_tuser;
            results_seen++;
            if (got_pixel.escaped)
                escaped_seen++;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result word col %0d row %0d iter %0d esc %0b",
                             $realtime, got_pixel.column, got_pixel.row,
                             got_pixel.iterations, got_pixel.escaped);
            end
            else
            begin
                want_pixel = pending_pixels.pop_front();
                if (got_pixel.column !== want_pixel.column || got_pixel.row !== want_pixel.row
                    || got_pixel.iterations !== want_pixel.iterations
                    || got_pixel.escaped !== want_pixel.escaped)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $write("%0t: result mismatch, expected col %0d row %0d iter %0d esc %0b, ",
                               $realtime, want_pixel.column, want_pixel.row,
                               want_pixel.iterations, want_pixel.escaped);
                        $display("got col %0d row %0d iter %0d esc %0b",
                                 got_pixel.column, got_pixel.row, got_pixel.iterations,
                                 got_pixel.escaped);
                    end
                end
            end
        end
    end

    // Ends a hung run: too long without any word accepted on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word accepted for %0d cycles", $realtime, quiet_cycles);
            $display("mandelbrot_escape_time verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_view();
        test_special_points();
        test_saturation();
        test_last_round_escape();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(60, 0);
        test_random_traffic(0, 60);
        test_random_traffic(33, 33);

        // Drain, then give the block time to show any stray word.
        settle();
        repeat (LATENCY_MAX)
            @(posedge clk);
        mismatches += pending_pixels.size();

        $display("Sent %0d pixel words under %0d views (%0d register writes), %0d results back.",
                 pixels_sent, views_set, reg_writes, results_seen);
        $display("Of those %0d escaped and %0d hit the round limit; %0d mismatches.",
                 escaped_seen, results_seen - escaped_seen, mismatches);
        if (mismatches == 0)
            $display("mandelbrot_escape_time verification clean");
        else
            $display("mandelbrot_escape_time verification failed");
        $finish;
    end

endmodule
